// ----- hdl/frr_pkg.sv -----
// ----------------------------------------------------------------------------
// frr_pkg
// Shared types and constants for the framed record receiver.
// ----------------------------------------------------------------------------
package frr_pkg;

    localparam int unsigned WORDS_PER_NODE = 5;
    localparam logic [7:0]  SYNC_RESET     = 8'd147;
    localparam logic [1:0]  LAST_BYTE_POS  = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef struct packed {
        logic        receiving;
        logic        word_valid;
        logic [7:0]  record_index;
        logic [2:0]  word_slot;
        logic [31:0] word_value;
        logic        frame_done;
    } result_t;

endpackage

// ----- hdl/frr_core.sv -----
// ----------------------------------------------------------------------------
// frr_core
// Frame state machine, byte packing and record counters; forms one result
// for every accepted byte.
// ----------------------------------------------------------------------------
module frr_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [7:0]       cfg_data,
    input  logic             step,
    input  logic [7:0]       rx_byte,
    output frr_pkg::result_t result
);

    logic [7:0]      sync_reg;
    frr_pkg::phase_t phase_reg, phase_next;
    logic [7:0]      length_reg, length_next;
    logic [1:0]      byte_pos_reg, byte_pos_next;
    logic [2:0]      word_pos_reg, word_pos_next;
    logic [7:0]      rec_cnt_reg, rec_cnt_next;
    logic [7:0]      hold_reg [3];
    logic            hold_we;
    logic            word_done;
    logic [3:0]      word_pos_inc;

    assign word_done    = (byte_pos_reg == frr_pkg::LAST_BYTE_POS);
    assign word_pos_inc = {1'b0, word_pos_reg} + 4'd1;

    // counters and packing
    always_comb begin
        length_next   = length_reg;
        byte_pos_next = byte_pos_reg;
        word_pos_next = word_pos_reg;
        rec_cnt_next  = rec_cnt_reg;
        hold_we       = 1'b0;
        case (phase_reg)
            frr_pkg::PH_LENGTH: begin
                length_next   = rx_byte;
                byte_pos_next = '0;
                word_pos_next = '0;
                rec_cnt_next  = '0;
            end
            frr_pkg::PH_PAYLOAD: begin
                if (!word_done) begin
                    hold_we       = 1'b1;
                    byte_pos_next = byte_pos_reg + 2'd1;
                end else begin
                    byte_pos_next = '0;
                    if (word_pos_inc >= 4'(frr_pkg::WORDS_PER_NODE)) begin
                        word_pos_next = '0;
                        rec_cnt_next  = rec_cnt_reg + 8'd1;
                    end else begin
                        word_pos_next = word_pos_inc[2:0];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        case (phase_reg)
            frr_pkg::PH_LENGTH: phase_next = frr_pkg::PH_PAYLOAD;
            frr_pkg::PH_PAYLOAD: begin
                if (rec_cnt_next == length_reg) begin
                    phase_next = frr_pkg::PH_IDLE;
                end else begin
                    phase_next = frr_pkg::PH_PAYLOAD;
                end
            end
            default: begin
                if (rx_byte == sync_reg) begin
                    phase_next = frr_pkg::PH_LENGTH;
                end else begin
                    phase_next = frr_pkg::PH_IDLE;
                end
            end
        endcase
    end

    // result of this beat
    always_comb begin
        result           = '0;
        result.receiving = (phase_next != frr_pkg::PH_IDLE);
        case (phase_reg)
            frr_pkg::PH_PAYLOAD: begin
                result.frame_done = (rec_cnt_next == length_reg);
                if (word_done) begin
                    result.word_valid   = 1'b1;
                    result.record_index = rec_cnt_reg;
                    result.word_slot    = word_pos_reg;
                    result.word_value   = {rx_byte, hold_reg[2], hold_reg[1], hold_reg[0]};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_reg     <= frr_pkg::SYNC_RESET;
            phase_reg    <= frr_pkg::PH_IDLE;
            length_reg   <= '0;
            byte_pos_reg <= '0;
            word_pos_reg <= '0;
            rec_cnt_reg  <= '0;
            hold_reg[0]  <= '0;
            hold_reg[1]  <= '0;
            hold_reg[2]  <= '0;
        end else begin
            if (cfg_we) begin
                sync_reg <= cfg_data;
            end
            if (step) begin
                phase_reg    <= phase_next;
                length_reg   <= length_next;
                byte_pos_reg <= byte_pos_next;
                word_pos_reg <= word_pos_next;
                rec_cnt_reg  <= rec_cnt_next;
                if (hold_we) begin
                    hold_reg[byte_pos_reg] <= rx_byte;
                end
            end
        end
    end

endmodule

// ----- hdl/frr_out_reg.sv -----
// ----------------------------------------------------------------------------
// frr_out_reg
// Result register; takes a new result whenever it is empty or being drained.
// ----------------------------------------------------------------------------
module frr_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  frr_pkg::result_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output frr_pkg::result_t out_data
);

    logic             valid_reg, valid_next;
    frr_pkg::result_t data_reg;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_valid || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_data   = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= in_data;
        end
    end

endmodule

// ----- hdl/framed_record_receiver.sv -----
// ----------------------------------------------------------------------------
// framed_record_receiver
// Sync and length framed byte receiver packing payload into 32-bit words.
// ----------------------------------------------------------------------------
// each result is registered and appears in the cycle after its byte beat is accepted
// throughput: one byte per cycle unless m_ready stalls, set by the single result register
// s_ready drops only while a result is held and m_ready is low
// reset (aresetn low, synchronous): idle, counters cleared, sync value 147
// ----------------------------------------------------------------------------
module framed_record_receiver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_receiving,
    output logic        m_word_valid,
    output logic [7:0]  m_record_index,
    output logic [2:0]  m_word_slot,
    output logic [31:0] m_word_value,
    output logic        m_frame_done
);

    frr_pkg::result_t core_result;
    frr_pkg::result_t out_result;
    logic             in_ready;
    logic             step;

    assign cfg_ready = 1'b1;
    assign s_ready   = in_ready;
    assign step      = s_valid && in_ready;

    frr_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_we  (cfg_valid),
        .cfg_data(cfg_data),
        .step    (step),
        .rx_byte (s_rx_byte),
        .result  (core_result)
    );

    frr_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (in_ready),
        .in_data  (core_result),
        .out_valid(m_valid),
        .out_ready(m_ready),
        .out_data (out_result)
    );

    assign m_receiving    = out_result.receiving;
    assign m_word_valid   = out_result.word_valid;
    assign m_record_index = out_result.record_index;
    assign m_word_slot    = out_result.word_slot;
    assign m_word_value   = out_result.word_value;
    assign m_frame_done   = out_result.frame_done;

endmodule

// ----- hdl/frr_checker.sv -----
// ----------------------------------------------------------------------------
// frr_checker
// Port level checks on the framed record receiver, bound to the top level.
// ----------------------------------------------------------------------------
module frr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_receiving,
    input logic        m_word_valid,
    input logic [7:0]  m_record_index,
    input logic [2:0]  m_word_slot,
    input logic [31:0] m_word_value,
    input logic        m_frame_done
);

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word_value)
            && $stable(m_record_index) && $stable(m_frame_done))
        else $error("result beat changed while stalled");

    // no word means zeroed word fields
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_word_valid |-> m_record_index == 8'd0 && m_word_slot == 3'd0
            && m_word_value == 32'd0)
        else $error("word fields not zero without a word");

    // a finished frame leaves the receiver idle
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_done |-> !m_receiving)
        else $error("frame done while still receiving");

    a_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word_valid |-> {1'b0, m_word_slot} < 4'(frr_pkg::WORDS_PER_NODE))
        else $error("word slot beyond record size");

    // no result right after reset, and input is taken then
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("result present after reset");

endmodule

bind framed_record_receiver frr_checker u_frr_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_receiving   (m_receiving),
    .m_word_valid  (m_word_valid),
    .m_record_index(m_record_index),
    .m_word_slot   (m_word_slot),
    .m_word_value  (m_word_value),
    .m_frame_done  (m_frame_done)
);
